// ===== hdl/mrsit_pkg.sv =====
// Shared constants and register codes for the mixed-radix subset index table.
`timescale 1ns / 1ps

package mrsit_pkg;

    localparam int DEF_MAX_DIMS   = 8;
    localparam int DEF_RADIX_BITS = 4;

    localparam int NUM_FIELDS  = 8;   // packed fields in each config word
    localparam int POS_W       = 3;   // width of a subset position field
    localparam int CNT_W       = 4;   // width of dimension counts
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int RADIX_PK_W  = 32;
    localparam int POS_PK_W    = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_DIMS   = 2'd0,
        CFG_RADIX       = 2'd1,
        CFG_SUBSET_DIMS = 2'd2,
        CFG_POSITIONS   = 2'd3
    } cfg_idx_t;

endpackage

// ===== hdl/mixed_radix_subset_index_table.sv =====
// Mixed-radix odometer with Horner projection of each assignment onto a subset.
`timescale 1ns / 1ps

// Each accepted input beat produces one table entry. A mixed-radix odometer
// (digit 0 most significant) walks every assignment of the full variable set;
// for each one the block returns its linear index (full_index), the index of
// the same assignment projected on the subset (subset_index) and a last flag
// on the final assignment, after which the odometer wraps to zero.
// Channels: in (valid/ready, restart), out (valid/ready, three fields) and a
// config write channel (cfg_valid/cfg_ready, cfg_index, cfg_data), always ready.
// A single shared multiply-add unit runs one Horner step per cycle over the
// subset positions (subset_dims of them, capped at 8), then a finishing step
// updates the odometer and loads the output register. in_ready drops while an
// entry is being computed, so no new beat is taken until the finishing step
// has loaded the output register and returned the block to idle.
// The output register decouples the sides: a new beat is accepted while a
// result waits; if out_ready stays low the finishing cycle holds until the
// output register frees. Reset clears the odometer, counter and registers
// (full_dims 1, others 0); restart=1 zeroes the odometer before the entry.
module mixed_radix_subset_index_table #(
    parameter int MAX_DIMS   = mrsit_pkg::DEF_MAX_DIMS,
    parameter int RADIX_BITS = mrsit_pkg::DEF_RADIX_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mrsit_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrsit_pkg::DATA_W-1:0]     cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mrsit_pkg::IDX_W-1:0]      full_index,
    output logic [mrsit_pkg::IDX_W-1:0]      subset_index,
    output logic                             last
);
    import mrsit_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    typedef logic [RADIX_BITS-1:0] digit_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        full_dims_reg, full_dims_next;
    logic [RADIX_PK_W-1:0]   radix_reg, radix_next;
    logic [CNT_W-1:0]        subset_dims_reg, subset_dims_next;
    logic [POS_PK_W-1:0]     positions_reg, positions_next;
    digit_t                  digit_reg [MAX_DIMS];
    digit_t                  digit_next [MAX_DIMS];
    logic [IDX_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]        step_reg, step_next;
    logic                    out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]        full_index_reg, full_index_next;
    logic [IDX_W-1:0]        subset_index_reg, subset_index_next;
    logic                    last_reg, last_next;

    logic [POS_W-1:0]        pos_field [NUM_FIELDS];
    digit_t                  rmax_field [NUM_FIELDS];
    logic [CNT_W-1:0]        n_eff, sn_eff;
    logic [POS_W-1:0]        cur_pos;
    digit_t                  cur_rmax, cur_digit;
    logic [RADIX_BITS:0]     cur_radix;
    logic [IDX_W-1:0]        mul_add;
    logic                    is_last, done_k, load;
    digit_t                  odo_digit [MAX_DIMS];

    always_comb
    begin
        for (int p = 0; p < NUM_FIELDS; p++)
        begin
            pos_field[p]  = positions_reg[p*POS_W +: POS_W];
            rmax_field[p] = radix_reg[p*RADIX_BITS +: RADIX_BITS];
        end
    end

    always_comb
    begin
        if (full_dims_reg == '0)
            n_eff = CNT_W'(1);
        else if (full_dims_reg > CNT_W'(MAX_DIMS))
            n_eff = CNT_W'(MAX_DIMS);
        else
            n_eff = full_dims_reg;
        sn_eff = (subset_dims_reg > CNT_W'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) : subset_dims_reg;
    end

    // one Horner step: acc * radix(pos) + digit(pos)
    always_comb
    begin
        cur_pos   = pos_field[step_reg[POS_W-1:0]];
        cur_rmax  = rmax_field[cur_pos];
        cur_radix = {1'b0, cur_rmax} + (RADIX_BITS+1)'(1);
        cur_digit = '0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            if ((CNT_W'(cur_pos) == CNT_W'(i)) && (CNT_W'(i) < n_eff))
                cur_digit = digit_reg[i];
        end
        mul_add = IDX_W'(acc_reg * IDX_W'(cur_radix)) + IDX_W'(cur_digit);
    end

    // last flag and odometer increment, least significant digit first
    always_comb
    begin
        is_last = 1'b1;
        done_k  = 1'b0;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if ((CNT_W'(k) < n_eff) && (digit_reg[k] < rmax_field[k]))
                is_last = 1'b0;
        end
        for (int k = MAX_DIMS - 1; k >= 0; k--)
        begin
            odo_digit[k] = digit_reg[k];
            if ((CNT_W'(k) < n_eff) && !done_k)
            begin
                if (digit_reg[k] < rmax_field[k])
                begin
                    odo_digit[k] = digit_reg[k] + RADIX_BITS'(1);
                    done_k       = 1'b1;
                end
                else
                    odo_digit[k] = '0;
            end
        end
    end

    assign load = (state_reg == S_RUN) && (step_reg >= sn_eff)
                  && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next        = state_reg;
        full_dims_next    = full_dims_reg;
        radix_next        = radix_reg;
        subset_dims_next  = subset_dims_reg;
        positions_next    = positions_reg;
        digit_next        = digit_reg;
        count_next        = count_reg;
        acc_next          = acc_reg;
        step_next         = step_reg;
        out_valid_next    = out_valid_reg;
        full_index_next   = full_index_reg;
        subset_index_next = subset_index_reg;
        last_next         = last_reg;

        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FULL_DIMS:   full_dims_next   = cfg_data[CNT_W-1:0];
                CFG_RADIX:       radix_next       = cfg_data[RADIX_PK_W-1:0];
                CFG_SUBSET_DIMS: subset_dims_next = cfg_data[CNT_W-1:0];
                CFG_POSITIONS:   positions_next   = cfg_data[POS_PK_W-1:0];
                default:         ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = S_RUN;
                    if (restart)
                    begin
                        for (int i = 0; i < MAX_DIMS; i++)
                            digit_next[i] = '0;
                        count_next = '0;
                    end
                end
            end
            S_RUN:
            begin
                if (step_reg < sn_eff)
                begin
                    acc_next  = mul_add;
                    step_next = step_reg + CNT_W'(1);
                end
                else if (load)
                begin
                    out_valid_next    = 1'b1;
                    full_index_next   = count_reg;
                    subset_index_next = acc_reg;
                    last_next         = is_last;
                    state_next        = S_IDLE;
                    if (is_last)
                    begin
                        for (int i = 0; i < MAX_DIMS; i++)
                            digit_next[i] = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        digit_next = odo_digit;
                        count_next = count_reg + IDX_W'(1);
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            full_dims_reg   <= CNT_W'(1);
            radix_reg       <= '0;
            subset_dims_reg <= '0;
            positions_reg   <= '0;
            for (int i = 0; i < MAX_DIMS; i++)
                digit_reg[i] <= '0;
            count_reg       <= '0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            full_dims_reg   <= full_dims_next;
            radix_reg       <= radix_next;
            subset_dims_reg <= subset_dims_next;
            positions_reg   <= positions_next;
            digit_reg       <= digit_next;
            count_reg       <= count_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        full_index_reg   <= full_index_next;
        subset_index_reg <= subset_index_next;
        last_reg         <= last_next;
    end

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign full_index   = full_index_reg;
    assign subset_index = subset_index_reg;
    assign last         = last_reg;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && restart) |=> (count_reg == '0))
        else $error("restart did not clear entry counter");

    a_wrap_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && is_last) |=> (count_reg == '0) && out_valid && last)
        else $error("odometer did not wrap after last entry");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !is_last) |=> (count_reg == $past(count_reg) + IDX_W'(1))
                               && (full_index == $past(count_reg)))
        else $error("entry counter did not advance by one");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (step_reg <= sn_eff))
        else $error("Horner step counter overran subset size");

endmodule

// ===== verif/mixed_radix_subset_index_table_tb.sv =====
// Testbench for the mixed-radix subset index table: odometer walk and Horner projection checks.
`timescale 1ns / 1ps

module mixed_radix_subset_index_table_tb;
    import mrsit_pkg::*;

    localparam int IDLE_PCT     = 37;
    localparam int SETTLE       = 12;      // idle margin before config writes and the final check
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_ITEMS   = 24;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [IDX_W-1:0] full;
        logic [IDX_W-1:0] subset;
        logic             last;
    } table_entry_t;

    // Tracks odometer state and registers; queues the entry each request yields.
    class index_table_tracker;
        logic [CNT_W-1:0]      full_dims_r;
        logic [RADIX_PK_W-1:0] radix_m1_r;
        logic [CNT_W-1:0]      subset_dims_r;
        logic [POS_PK_W-1:0]   positions_r;
        logic [3:0]            digits [NUM_FIELDS];
        logic [IDX_W-1:0]      entry_count;
        table_entry_t          pending_entries [$];
        int                    errors;

        function new();
            full_dims_r   = 4'd1;
            radix_m1_r    = '0;
            subset_dims_r = '0;
            positions_r   = '0;
            foreach (digits[i]) digits[i] = '0;
            entry_count   = '0;
            errors        = 0;
        endfunction

        function logic [IDX_W-1:0] radix_limit(int unsigned pos);
            return IDX_W'((radix_m1_r >> (4 * pos)) & 32'hF);
        endfunction

        function void write_reg(cfg_idx_t idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_FULL_DIMS:   full_dims_r   = data[CNT_W-1:0];
                CFG_RADIX:       radix_m1_r    = data[RADIX_PK_W-1:0];
                CFG_SUBSET_DIMS: subset_dims_r = data[CNT_W-1:0];
                CFG_POSITIONS:   positions_r   = data[POS_PK_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic clear_odo);
            int unsigned  n;
            int unsigned  sn;
            int unsigned  pos;
            int           k;
            logic [31:0]  acc;
            logic         wrap;
            table_entry_t entry;
            n  = (full_dims_r == 0) ? 1 : ((full_dims_r > 8) ? 8 : full_dims_r);
            sn = (subset_dims_r > 8) ? 8 : subset_dims_r;
            if (clear_odo)
            begin
                foreach (digits[i]) digits[i] = '0;
                entry_count = '0;
            end
            acc = '0;
            for (int j = 0; j < sn; j++)
            begin
                pos = positions_r[3*j +: 3];
                acc = acc * (radix_limit(pos) + 32'd1) + ((pos < n) ? 32'(digits[pos]) : 32'd0);
            end
            wrap = 1'b1;
            for (int j = 0; j < n; j++)
                if (32'(digits[j]) < radix_limit(j))
                    wrap = 1'b0;
            entry.full   = entry_count;
            entry.subset = acc;
            entry.last   = wrap;
            pending_entries = {pending_entries, entry};
            if (wrap)
            begin
                foreach (digits[i]) digits[i] = '0;
                entry_count = '0;
            end
            else
            begin
                // digits above their limit (radix changed mid-table) carry like full ones
                k = int'(n) - 1;
                while (k >= 0)
                begin
                    if (32'(digits[k]) < radix_limit(k))
                    begin
                        digits[k] = digits[k] + 4'd1;
                        break;
                    end
                    digits[k] = '0;
                    k--;
                end
                entry_count = entry_count + 32'd1;
            end
        endfunction

        function void check_entry(logic [IDX_W-1:0] full, logic [IDX_W-1:0] subset,
                                  logic last_flag);
            table_entry_t want;
            if (pending_entries.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected entry: full %0d subset %0d last %0b",
                             $realtime, full, subset, last_flag);
                return;
            end
            want = pending_entries.pop_front();
            if (full !== want.full || subset !== want.subset || last_flag !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] entry mismatch: exp full %0d subset %0d last %0b,",
                             $realtime, want.full, want.subset, want.last,
                             " got full %0d subset %0d last %0b",
                             full, subset, last_flag);
            end
        endfunction

        function int outstanding();
            return pending_entries.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 restart;
    logic                 out_valid;
    logic                 out_ready;
    logic [IDX_W-1:0]     full_index;
    logic [IDX_W-1:0]     subset_index;
    logic                 last;

    bit                   calm;
    bit                   hold_req;
    int                   cycle_count;
    index_table_tracker   sb;

    mixed_radix_subset_index_table DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .full_index   (full_index),
        .subset_index (subset_index),
        .last         (last)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // beat monitors: values seen here are the ones present at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
            if (in_valid && in_ready)
                sb.note_request(restart);
            if (out_valid && out_ready)
                sb.check_entry(full_index, subset_index, last);
        end
    end

    // receiver: random back-pressure, plus long holds on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Waits for the block to drain, then loads all four registers back to back.
    task automatic setup_table(input logic [DATA_W-1:0] fd, input logic [DATA_W-1:0] rad,
                               input logic [DATA_W-1:0] sd, input logic [DATA_W-1:0] pos);
        cfg_idx_t          regs [4];
        logic [DATA_W-1:0] vals [4];
        regs = '{CFG_FULL_DIMS, CFG_RADIX, CFG_SUBSET_DIMS, CFG_POSITIONS};
        vals = '{fd, rad, sd, pos};
        // let the monitor log the last accepted request first
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_run(input int count, input int restart_pct, input bit lead_restart);
        for (int k = 0; k < count; k++)
        begin
            while (!calm && $urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            restart  <= (k == 0 && lead_restart) || ($urandom_range(0, 99) < restart_pct);
            @(posedge clk);
            while (!in_ready) @(posedge clk);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int                  sent;
        int                  phase;
        int                  kind;
        int                  items;
        int                  pct;
        int unsigned         n;
        int unsigned         size;
        logic [CNT_W-1:0]    fd;
        logic [CNT_W-1:0]    sd;
        logic [DATA_W-1:0]   fd_word;
        logic [RADIX_PK_W-1:0] rad;
        logic [POS_PK_W-1:0] pos;

        sb        = new();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FULL_DIMS;
        cfg_data  = '0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: single digit of radix 1, every entry wraps
        send_run(2, 0, 1'b1);
        // full_dims 0 acts as 1; second subset position lies past the full set
        setup_table(32'd0, 32'h0000_0021, 32'd2, 32'h0000_0028);
        send_run(3, 0, 1'b0);
        // oversized counts clamp to 8; radix 16 everywhere, identity positions
        setup_table(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FA_C688);
        send_run(4, 0, 1'b1);
        // drop all radices to 1 mid-table: digits above limit count as full
        setup_table(32'd8, 32'd0, 32'd8, 32'h00FA_C688);
        send_run(2, 0, 1'b0);
        // 2x3x2 table, repeated subset position, walk it through the wrap
        setup_table(32'd3, 32'h0000_0121, 32'd3, 32'h0000_0009);
        send_run(13, 0, 1'b0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            rad  = '0;
            if (kind < 7)
            begin
                fd = CNT_W'($urandom_range(1, 4));
                for (int p = 0; p < 8; p++) rad[4*p +: 4] = 4'($urandom_range(0, 3));
                sd = CNT_W'($urandom_range(0, 32'(fd) + 32'd1));
                for (int j = 0; j < 8; j++) pos[3*j +: 3] = POS_W'($urandom_range(0, 32'(fd)));
                fd_word = DATA_W'(fd);
            end
            else if (kind == 7)
            begin
                fd = CNT_W'($urandom_range(5, 8));
                for (int p = 0; p < 8; p++) rad[4*p +: 4] = 4'($urandom_range(0, 1));
                sd = CNT_W'($urandom_range(0, 8));
                pos = POS_PK_W'($urandom());
                fd_word = DATA_W'(fd);
            end
            else if (kind == 8)
            begin
                fd = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
                rad = $urandom();
                sd = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
                pos = POS_PK_W'($urandom());
                fd_word = ($urandom() & 32'hFFFF_FFF0) | 32'(fd);
            end
            else
            begin
                fd = 4'd8;
                rad = 32'hFFFF_FFFF;
                sd = 4'd8;
                pos = POS_PK_W'($urandom());
                fd_word = DATA_W'(fd);
            end

            n = (fd == 0) ? 1 : ((fd > 8) ? 8 : fd);
            size = 1;
            for (int p = 0; p < n; p++)
            begin
                size = size * (rad[4*p +: 4] + 1);
                if (size > 1000) size = 1000;
            end
            items = (size <= 30) ? size * 2 + $urandom_range(0, 3) : $urandom_range(20, 50);
            pct = (kind == 8 || $urandom_range(0, 4) == 0) ? 25 : 2;
            // keep offering beats through a long receiver hold
            if ((phase == 2 || phase == 8) && items < HOLD_ITEMS)
                items = HOLD_ITEMS;

            setup_table(fd_word, rad, 32'(sd), 32'(pos));
            @(negedge clk);
            calm     = (phase % 6 == 1);
            hold_req = (phase == 2 || phase == 8);
            @(posedge clk);
            send_run(items, pct, $urandom_range(0, 3) == 0);
            sent  += items;
            phase++;
        end

        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
